// ===== rtl/llsa_pkg.sv =====
// Package for the least loaded server assigner.
// Item, result, token and cell write types, status codes and sizes.
// No dependencies.
package llsa_pkg;

	localparam int unsigned MAX_SERVERS_DEF = 8;
	localparam int unsigned SRV_IDX_W       = 6;
	localparam int unsigned TIME_W          = 10;
	localparam int unsigned COUNT_W         = 10;
	localparam int unsigned BUSY_W          = 32;
	localparam int unsigned PROD_W          = TIME_W + COUNT_W;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_JOB  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [TIME_W-1:0]  item_time;
		logic [COUNT_W-1:0] item_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        server_index;
		logic [BUSY_W-1:0] server_busy;
		logic [BUSY_W-1:0] makespan;
		logic [1:0]        status;
	} result_t;

	// running minimum handed from cell to cell
	typedef struct packed {
		logic                 vld;
		logic                 found;
		logic [BUSY_W-1:0]    busy;
		logic [TIME_W-1:0]    itime;
		logic [SRV_IDX_W-1:0] idx;
	} token_t;

	// broadcast write into one cell
	typedef struct packed {
		logic                 en;
		logic                 load;
		logic [SRV_IDX_W-1:0] idx;
		logic [TIME_W-1:0]    itime;
		logic [BUSY_W-1:0]    busy;
	} cell_wr_t;

endpackage

// ===== rtl/llsa_cell.sv =====
// One server cell: item time, busy time and loaded flag.
// Passes the running minimum token to its neighbor each cycle.
// Depends on llsa_pkg.
module llsa_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  llsa_pkg::cell_wr_t wr,
	input  llsa_pkg::token_t   tok_in,
	output llsa_pkg::token_t   tok_out
);

	logic                            loaded_q;
	logic [llsa_pkg::BUSY_W-1:0]     busy_q;
	logic [llsa_pkg::TIME_W-1:0]     itime_q;
	logic                            sel;
	logic                            take;
	logic                            tok_vld_q;
	logic                            tok_found_q;
	logic [llsa_pkg::BUSY_W-1:0]     tok_busy_q;
	logic [llsa_pkg::TIME_W-1:0]     tok_itime_q;
	logic [llsa_pkg::SRV_IDX_W-1:0]  tok_idx_q;

	assign sel  = wr.en && (wr.idx == llsa_pkg::SRV_IDX_W'(CELL_IDX));
	// later cell wins ties
	assign take = loaded_q && (!tok_in.found || (busy_q <= tok_in.busy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			if (sel && wr.load)
				loaded_q <= 1'b1;
			tok_vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			busy_q <= wr.busy;
			if (wr.load)
				itime_q <= wr.itime;
		end
		tok_found_q <= tok_in.found | take;
		if (take) begin
			tok_busy_q  <= busy_q;
			tok_itime_q <= itime_q;
			tok_idx_q   <= llsa_pkg::SRV_IDX_W'(CELL_IDX);
		end else begin
			tok_busy_q  <= tok_in.busy;
			tok_itime_q <= tok_in.itime;
			tok_idx_q   <= tok_in.idx;
		end
	end

	assign tok_out = {tok_vld_q, tok_found_q, tok_busy_q, tok_itime_q, tok_idx_q};

endmodule

// ===== rtl/least_loaded_server_assigner_top.sv =====
// Least loaded server assigner: top level with control and cell chain.
// A load item: strobe in the cycle after accept. A job item: token walks
// MAX_SERVERS cells, then multiply, then add and write back; strobe
// registered from the add step. busy is high while a job is in flight,
// so no item is taken until the job is done; one load per cycle while
// no job is in flight; the result strobe never waits. Reset clears
// loaded flags, server count, makespan and control state.
module least_loaded_server_assigner_top #(
	parameter int unsigned MAX_SERVERS = llsa_pkg::MAX_SERVERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  llsa_pkg::in_item_t item,
	output logic               done,
	output llsa_pkg::result_t  result
);

	localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);

	typedef enum logic [1:0] {IDLE, SCAN, MUL, ADD} state_t;

	state_t                           state_q;
	logic [CNT_W-1:0]                 count_q;
	logic [llsa_pkg::BUSY_W-1:0]      max_q;
	logic [llsa_pkg::COUNT_W-1:0]     n_q;
	logic [llsa_pkg::BUSY_W-1:0]      best_busy_q;
	logic [llsa_pkg::TIME_W-1:0]      best_time_q;
	logic [llsa_pkg::SRV_IDX_W-1:0]   best_idx_q;
	logic [llsa_pkg::PROD_W-1:0]      prod_q;
	logic                             done_q;
	llsa_pkg::result_t                result_q;

	logic                             accept;
	logic                             full;
	logic [llsa_pkg::BUSY_W:0]        sum;
	logic                             sat;
	logic [llsa_pkg::BUSY_W-1:0]      nb;
	llsa_pkg::cell_wr_t               wr;
	llsa_pkg::token_t                 tok [0:MAX_SERVERS];

	assign accept = start && (state_q == IDLE);
	assign full   = (count_q == CNT_W'(MAX_SERVERS));
	assign sum    = {1'b0, best_busy_q} + (llsa_pkg::BUSY_W + 1)'(prod_q);
	assign sat    = sum[llsa_pkg::BUSY_W];
	assign nb     = sat ? '1 : sum[llsa_pkg::BUSY_W-1:0];

	always_comb begin
		wr       = '0;
		wr.itime = item.item_time;
		if (accept && (item.mode == llsa_pkg::MODE_LOAD) && !full) begin
			wr.en   = 1'b1;
			wr.load = 1'b1;
			wr.idx  = llsa_pkg::SRV_IDX_W'(count_q);
		end else if (state_q == ADD) begin
			wr.en   = 1'b1;
			wr.idx  = best_idx_q;
			wr.busy = nb;
		end
	end

	always_comb begin
		tok[0]     = '0;
		tok[0].vld = accept && (item.mode == llsa_pkg::MODE_JOB) && (count_q != '0);
	end

	for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
		llsa_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr),
			.tok_in (tok[g]),
			.tok_out(tok[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			max_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						if (item.mode == llsa_pkg::MODE_LOAD) begin
							done_q <= 1'b1;
							if (!full)
								count_q <= count_q + CNT_W'(1);
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					if (tok[MAX_SERVERS].vld)
						state_q <= MUL;
				end
				MUL: begin
					state_q <= ADD;
				end
				ADD: begin
					done_q  <= 1'b1;
					state_q <= IDLE;
					if (nb > max_q)
						max_q <= nb;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= item.item_count;
			if (item.mode == llsa_pkg::MODE_LOAD) begin
				result_q.server_busy <= '0;
				result_q.makespan    <= max_q;
				if (full) begin
					result_q.server_index <= '0;
					result_q.status       <= llsa_pkg::ST_FULL;
				end else begin
					result_q.server_index <= 3'(count_q);
					result_q.status       <= llsa_pkg::ST_OK;
				end
			end else if (count_q == '0) begin
				result_q.server_index <= '0;
				result_q.server_busy  <= '0;
				result_q.makespan     <= '0;
				result_q.status       <= llsa_pkg::ST_EMPTY;
			end
		end
		if ((state_q == SCAN) && tok[MAX_SERVERS].vld) begin
			best_busy_q <= tok[MAX_SERVERS].busy;
			best_time_q <= tok[MAX_SERVERS].itime;
			best_idx_q  <= tok[MAX_SERVERS].idx;
		end
		if (state_q == MUL)
			prod_q <= best_time_q * n_q;
		if (state_q == ADD) begin
			result_q.server_index <= best_idx_q[2:0];
			result_q.server_busy  <= nb;
			result_q.makespan     <= (nb > max_q) ? nb : max_q;
			result_q.status       <= sat ? llsa_pkg::ST_SAT : llsa_pkg::ST_OK;
		end
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for least_loaded_server_assigner_top: directed and random append and job items.
// Predicts each result from its own copy of the server table; uses llsa_pkg and the RTL top.
module tb_top;

	localparam int NSRV     = 8;
	localparam int LIMIT    = 400000;
	localparam int END_TAIL = 20;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	llsa_pkg::in_item_t item = '0;
	logic               done;
	llsa_pkg::result_t  result;

	least_loaded_server_assigner_top #(.MAX_SERVERS(NSRV)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// server table as the block should hold it
	logic [llsa_pkg::TIME_W-1:0] srv_time [NSRV];
	logic [llsa_pkg::BUSY_W-1:0] srv_busy [NSRV];
	int                          srv_count = 0;
	logic [llsa_pkg::BUSY_W-1:0] span = '0;

	llsa_pkg::result_t result_q [$];
	int      mismatches = 0;
	int      cycles = 0;
	int      idle_pct = 0;
	int      loads_sent = 0;
	int      n_jobs = 0;
	int      n_appends = 0;
	int      n_empty = 0;
	int      n_full = 0;
	int      n_sat = 0;

	function automatic llsa_pkg::result_t assign_item(input llsa_pkg::in_item_t it);
		llsa_pkg::result_t           r;
		int                          pick;
		int                          k;
		logic [63:0]                 total;
		logic [llsa_pkg::BUSY_W-1:0] nb;
		r = '0;
		if (it.mode == llsa_pkg::MODE_LOAD) begin
			r.makespan = span;
			if (srv_count >= NSRV) begin
				r.status = llsa_pkg::ST_FULL;
				n_full++;
			end else begin
				srv_time[srv_count] = it.item_time;
				srv_busy[srv_count] = '0;
				r.server_index = srv_count[2:0];
				r.status = llsa_pkg::ST_OK;
				srv_count++;
				n_appends++;
			end
		end else if (srv_count == 0) begin
			r.status = llsa_pkg::ST_EMPTY;
			n_empty++;
		end else begin
			// ties go to the newest server
			pick = srv_count - 1;
			for (k = srv_count - 2; k >= 0; k--) begin
				if (srv_busy[k] < srv_busy[pick])
					pick = k;
			end
			total = {32'd0, srv_busy[pick]} +
				{54'd0, srv_time[pick]} * {54'd0, it.item_count};
			if (total > 64'h0000_0000_FFFF_FFFF) begin
				nb = '1;
				r.status = llsa_pkg::ST_SAT;
				n_sat++;
			end else begin
				nb = total[llsa_pkg::BUSY_W-1:0];
				r.status = llsa_pkg::ST_OK;
			end
			srv_busy[pick] = nb;
			if (nb > span)
				span = nb;
			r.server_index = pick[2:0];
			r.server_busy = nb;
			r.makespan = span;
			n_jobs++;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0d: %s mismatch, expected %0h got %0h", cycles, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		llsa_pkg::result_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n) begin
			if (done) begin
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0d: result with nothing pending", cycles);
				end else begin
					want = result_q.pop_front();
					check_field("server_index", 32'(want.server_index), 32'(result.server_index));
					check_field("server_busy", want.server_busy, result.server_busy);
					check_field("makespan", want.makespan, result.makespan);
					check_field("status", 32'(want.status), 32'(result.status));
				end
			end
			if (start && !busy)
				result_q.push_back(assign_item(item));
		end
	end

	task automatic send_item(input logic mode, input logic [llsa_pkg::TIME_W-1:0] t,
		input logic [llsa_pkg::COUNT_W-1:0] n);
		llsa_pkg::in_item_t it;
		it.mode = mode;
		it.item_time = t;
		it.item_count = n;
		if (mode == llsa_pkg::MODE_LOAD)
			loads_sent++;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (result_q.size() != 0);
	endtask

	task automatic test_empty_table;
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'd0);
		send_item(llsa_pkg::MODE_JOB, 10'h3FF, 10'h3FF);
		drain();
	endtask

	task automatic test_single_server;
		send_item(llsa_pkg::MODE_LOAD, 10'h3FF, 10'd0);
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'd0);
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'h3FF);
		send_item(llsa_pkg::MODE_JOB, 10'h3FF, 10'd1);
		drain();
	endtask

	task automatic test_ties;
		send_item(llsa_pkg::MODE_LOAD, 10'd1, 10'd0);
		send_item(llsa_pkg::MODE_LOAD, 10'h3FF, 10'd0);
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'd0);
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'd1);
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'h3FF);
		send_item(llsa_pkg::MODE_JOB, 10'd0, 10'd2);
		drain();
	endtask

	task automatic test_random;
		int pcts [4] = '{0, 69, 29, 0};
		int jobs;
		logic [llsa_pkg::TIME_W-1:0] t;
		logic [llsa_pkg::COUNT_W-1:0] n;
		foreach (pcts[p]) begin
			idle_pct = pcts[p];
			jobs = 0;
			while (jobs < 255) begin
				if ($urandom_range(9) == 0) begin
					// a zero-time server would take every later job
					t = (loads_sent >= NSRV) ? 10'($urandom) : 10'($urandom_range(1, 1023));
					send_item(llsa_pkg::MODE_LOAD, t, 10'($urandom));
				end else begin
					case ($urandom_range(7))
						0: n = 10'd0;
						1: n = 10'h3FF;
						default: n = 10'($urandom);
					endcase
					send_item(llsa_pkg::MODE_JOB, 10'($urandom), n);
					jobs++;
				end
			end
			// sender holds off until the block has answered everything
			drain();
		end
		idle_pct = 0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_single_server();
		test_ties();
		test_random();
		repeat (END_TAIL) @(posedge clk);
		$display("covered %0d jobs, %0d appends, %0d empty-table jobs,", n_jobs, n_appends,
			n_empty);
		$display("%0d appends to a full table, %0d saturating jobs; %0d mismatches", n_full,
			n_sat, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/llsa_pkg.sv
rtl/llsa_cell.sv
rtl/least_loaded_server_assigner_top.sv
tb/tb_top.sv
